// ----- src/ftpd_pkg.sv -----
// Package for the force/torque packet decoder: payload structs, queue entry,
// record layout constants, register map and result codes. No dependencies.
`default_nettype none

package ftpd_pkg;

  localparam int RecordBytes = 36;
  localparam int SeqLast     = 3;
  localparam int StatusLast  = 11;
  localparam int AxisFirst   = 12;
  localparam int Overlong    = 37;
  localparam int NumAxes     = 6;
  localparam int ForceAxes   = 3;
  localparam int PosW        = 6;
  localparam int AxisIdxW    = 3;
  localparam int WordW       = 32;
  localparam int GainW       = 40;
  localparam int AxisW       = 40;
  localparam int CountW      = 48;
  localparam int CfgDataW    = 64;
  localparam int CfgAddrW    = 4;
  localparam int QDepth      = 4;
  localparam int QPtrW       = 2;
  localparam int QCntW       = 3;

  localparam logic [GainW-1:0]  GainReset = 40'd281474977;
  localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};

  localparam logic REG_FORCE_GAIN  = 1'b0;
  localparam logic REG_TORQUE_GAIN = 1'b1;

  localparam logic [1:0] OUTCOME_GOOD       = 2'd0;
  localparam logic [1:0] OUTCOME_BAD_STATUS = 2'd1;
  localparam logic [1:0] OUTCOME_REJECT     = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
    logic       source_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              outcome;
    logic [31:0]             sequence_number;
    logic signed [AxisW-1:0] force_x;
    logic signed [AxisW-1:0] force_y;
    logic signed [AxisW-1:0] force_z;
    logic signed [AxisW-1:0] torque_x;
    logic signed [AxisW-1:0] torque_y;
    logic signed [AxisW-1:0] torque_z;
    logic [CountW-1:0]       dropped_total;
    logic [CountW-1:0]       bad_status_total;
  } out_item_t;

  typedef struct packed {
    logic                is_axis;
    logic [AxisIdxW-1:0] axis_idx;
    logic                neg;
    logic [WordW-1:0]    mag;
    logic [GainW-1:0]    gain;
    logic                is_eop;
    logic                reject;
    logic                status_bad;
    logic [WordW-1:0]    seq;
  } task_t;

endpackage

`default_nettype wire

// ----- src/ftpd_regs.sv -----
// APB-style configuration registers: force and torque gains.
// Depends on ftpd_pkg.
`default_nettype none

module ftpd_regs import ftpd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output logic      [CfgDataW-1:0] cfg_prdata,
  output logic                     cfg_pready,
  output logic      [GainW-1:0]    force_gain,
  output logic      [GainW-1:0]    torque_gain
);

  logic [GainW-1:0] force_gain_r, force_gain_nxt;
  logic [GainW-1:0] torque_gain_r, torque_gain_nxt;
  logic             wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    force_gain_nxt  = force_gain_r;
    torque_gain_nxt = torque_gain_r;
    if (wr) begin
      case (cfg_paddr[3])
        REG_FORCE_GAIN:  force_gain_nxt  = cfg_pwdata[GainW-1:0];
        REG_TORQUE_GAIN: torque_gain_nxt = cfg_pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3])
      REG_FORCE_GAIN:  cfg_prdata = {{(CfgDataW-GainW){1'b0}}, force_gain_r};
      REG_TORQUE_GAIN: cfg_prdata = {{(CfgDataW-GainW){1'b0}}, torque_gain_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_gain_r  <= GainReset;
      torque_gain_r <= GainReset;
    end else begin
      force_gain_r  <= force_gain_nxt;
      torque_gain_r <= torque_gain_nxt;
    end
  end

  assign force_gain  = force_gain_r;
  assign torque_gain = torque_gain_r;

endmodule

`default_nettype wire

// ----- src/ftpd_front.sv -----
// Front end: accepts payload bytes, assembles big-endian words, classifies
// record positions and pushes axis and end-of-datagram tasks. Depends on ftpd_pkg.
`default_nettype none

module ftpd_front import ftpd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  input  wire logic [GainW-1:0] force_gain,
  input  wire logic [GainW-1:0] torque_gain,
  input  wire logic             q_full,
  output logic                  push,
  output task_t                 push_task
);

  logic [PosW-1:0]  pos_r, pos_nxt, pos_adv;
  logic [WordW-1:0] asm_r, asm_nxt;
  logic [WordW-1:0] held_r, held_nxt;
  logic             status_r, status_nxt;
  logic [PosW-1:0]  axis_off;
  logic             acc;
  logic             axis_hit;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign axis_off = pos_r - PosW'(AxisFirst);

  always_comb begin
    pos_adv    = pos_r;
    asm_nxt    = asm_r;
    held_nxt   = held_r;
    status_nxt = status_r;
    axis_hit   = 1'b0;
    if (pos_r < PosW'(RecordBytes)) begin
      asm_nxt = {asm_r[WordW-9:0], in_data.data_byte};
      if (pos_r == PosW'(SeqLast)) begin
        held_nxt = asm_nxt;
      end else if (pos_r == PosW'(StatusLast)) begin
        status_nxt = (asm_nxt != '0);
      end else if (pos_r >= PosW'(AxisFirst) && pos_r[1:0] == 2'b11) begin
        axis_hit = 1'b1;
      end
      pos_adv = pos_r + PosW'(1);
    end else begin
      pos_adv = PosW'(Overlong);
    end
    pos_nxt = in_data.end_of_packet ? '0 : pos_adv;
  end

  always_comb begin
    push_task            = '0;
    push_task.is_axis    = axis_hit;
    push_task.axis_idx   = axis_off[AxisIdxW+1:2];
    push_task.neg        = asm_nxt[WordW-1];
    push_task.mag        = asm_nxt[WordW-1] ? (~asm_nxt + WordW'(1)) : asm_nxt;
    push_task.gain       = (axis_off[AxisIdxW+1:2] < AxisIdxW'(ForceAxes)) ?
                           force_gain : torque_gain;
    push_task.is_eop     = in_data.end_of_packet;
    push_task.reject     = (pos_adv != PosW'(RecordBytes)) || !in_data.source_ok;
    push_task.status_bad = status_nxt;
    push_task.seq        = held_nxt;
  end

  assign push = acc && (axis_hit || in_data.end_of_packet);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      asm_r    <= '0;
      held_r   <= '0;
      status_r <= 1'b0;
    end else if (acc) begin
      pos_r    <= pos_nxt;
      asm_r    <= asm_nxt;
      held_r   <= held_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/ftpd_fifo.sv -----
// Task queue between the front end and the back end, four entries in flops.
// Depends on ftpd_pkg.
`default_nettype none

module ftpd_fifo import ftpd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire task_t push_task,
  input  wire logic  pop,
  output task_t      pop_task,
  output logic       full,
  output logic       empty
);

  task_t            mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCntW'(QDepth));
  assign empty    = (cnt_r == '0);
  assign pop_task = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_task;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/ftpd_back.sv -----
// Back end: multiply stage, scale/finalize stage with sequence and status
// counters, and the result register. Depends on ftpd_pkg.
`default_nettype none

module ftpd_back import ftpd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  wire task_t q_task,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_data
);

  logic                en;
  logic                a_valid_r;
  task_t               a_task_r;
  logic [63:0]         a_lo_r;
  logic [AxisW-1:0]    a_hi_r;

  logic [AxisW-1:0]    scaled_r [NumAxes];
  logic [AxisW-1:0]    scaled_nxt [NumAxes];
  logic [AxisW-1:0]    op_a, op_b, op_k, axis_val;

  logic [WordW-1:0]    prev_r, prev_nxt;
  logic [CountW-1:0]   drop_r, drop_nxt;
  logic [CountW-1:0]   bad_r, bad_nxt;
  logic [WordW-1:0]    expected;
  logic [WordW:0]      diff;
  logic [WordW-1:0]    missed;
  logic [CountW:0]     drop_sum;

  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  assign en  = !(out_valid_r && out_stall);
  assign pop = en && !q_empty;

  // floor(+/-mag * gain / 2^32); negative side folds the negate into one add
  always_comb begin
    op_a = {8'd0, a_lo_r[63:32]};
    op_b = a_hi_r;
    op_k = '0;
    if (a_task_r.neg) begin
      op_a = ~op_a;
      op_b = ~op_b;
      op_k = (a_lo_r[31:0] != '0) ? AxisW'(1) : AxisW'(2);
    end
    axis_val = op_a + op_b + op_k;
    for (int i = 0; i < NumAxes; i++) begin
      scaled_nxt[i] = scaled_r[i];
      if (a_valid_r && a_task_r.is_axis && a_task_r.axis_idx == AxisIdxW'(i)) begin
        scaled_nxt[i] = axis_val;
      end
    end
  end

  always_comb begin
    expected = prev_r + WordW'(1);
    diff     = {1'b0, a_task_r.seq} - {1'b0, expected};
    missed   = (!diff[WordW] && diff[WordW-1:0] != '0) ? diff[WordW-1:0] : WordW'(1);
    drop_sum = {1'b0, drop_r} + {{(CountW-WordW+1){1'b0}}, missed};

    prev_nxt      = prev_r;
    drop_nxt      = drop_r;
    bad_nxt       = bad_r;
    out_nxt       = '0;
    out_valid_nxt = a_valid_r && a_task_r.is_eop;

    if (a_valid_r && a_task_r.is_eop) begin
      if (a_task_r.reject) begin
        out_nxt.outcome = OUTCOME_REJECT;
      end else if (a_task_r.status_bad) begin
        bad_nxt = (bad_r == CountMax) ? bad_r : bad_r + CountW'(1);
        out_nxt.outcome         = OUTCOME_BAD_STATUS;
        out_nxt.sequence_number = a_task_r.seq;
      end else begin
        if (prev_r != '0 && a_task_r.seq != expected) begin
          drop_nxt = drop_sum[CountW] ? CountMax : drop_sum[CountW-1:0];
        end
        prev_nxt = a_task_r.seq;
        out_nxt.outcome         = OUTCOME_GOOD;
        out_nxt.sequence_number = a_task_r.seq;
        out_nxt.force_x         = scaled_nxt[0];
        out_nxt.force_y         = scaled_nxt[1];
        out_nxt.force_z         = scaled_nxt[2];
        out_nxt.torque_x        = scaled_nxt[3];
        out_nxt.torque_y        = scaled_nxt[4];
        out_nxt.torque_z        = scaled_nxt[5];
      end
    end
    out_nxt.dropped_total    = drop_nxt;
    out_nxt.bad_status_total = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_task_r <= q_task;
      a_lo_r   <= q_task.mag * q_task.gain[31:0];
      a_hi_r   <= AxisW'(q_task.mag * q_task.gain[GainW-1:32]);
      for (int i = 0; i < NumAxes; i++) begin
        scaled_r[i] <= scaled_nxt[i];
      end
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      drop_r      <= '0;
      bad_r       <= '0;
    end else if (en) begin
      a_valid_r   <= !q_empty;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      drop_r      <= drop_nxt;
      bad_r       <= bad_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- src/force_torque_packet_decoder.sv -----
// Top level of the force/torque packet decoder: configuration registers,
// front end, task queue and back end. Depends on ftpd_pkg and the ftpd_* modules.
`default_nettype none

// Takes one UDP payload byte per cycle while in_stall is low. It presents one
// result per datagram; the final byte's task passes through the queue, the
// multiply stage register and the result register. The front end assembles
// the 36-byte record and queues one task per axis word and one per datagram
// end, merged into one task when both fall on the same byte, into a four-entry
// queue. The back end scales each axis in a 32x32 plus 32x8 multiply stage
// followed by a combine stage, then updates the drop and bad-status counters
// and loads the result register. in_stall rises only when the queue is full,
// which happens only while the result register is held by out_stall. Gains are
// sampled as each axis word completes.
module force_torque_packet_decoder import ftpd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output logic      [CfgDataW-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  logic [GainW-1:0] force_gain, torque_gain;
  logic             q_full, q_empty, push, pop;
  task_t            push_task, pop_task;

  ftpd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .force_gain  (force_gain),
    .torque_gain (torque_gain)
  );

  ftpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .force_gain  (force_gain),
    .torque_gain (torque_gain),
    .q_full      (q_full),
    .push        (push),
    .push_task   (push_task)
  );

  ftpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_task (push_task),
    .pop       (pop),
    .pop_task  (pop_task),
    .full      (q_full),
    .empty     (q_empty)
  );

  ftpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_task    (pop_task),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- src/ftpd_checker.sv -----
// Port-level checks for the force/torque packet decoder, bound to the top level.
// Depends on ftpd_pkg.
`default_nettype none

module ftpd_checker import ftpd_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.outcome == OUTCOME_GOOD ||
                   out_data.outcome == OUTCOME_BAD_STATUS ||
                   out_data.outcome == OUTCOME_REJECT))
    else $error("undefined outcome code");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OUTCOME_REJECT |->
      out_data.sequence_number == '0 && out_data.force_x == '0 &&
      out_data.torque_z == '0)
    else $error("rejected datagram carries payload");

  a_bad_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OUTCOME_BAD_STATUS |->
      out_data.bad_status_total != '0 && out_data.force_y == '0)
    else $error("bad status not counted");

endmodule

bind force_torque_packet_decoder ftpd_checker u_ftpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- dv/ftpd_sample_checker.sv -----
// Sample checker for the force/torque packet decoder: tracks gain writes, decodes every
// accepted byte into the expected record and compares each result transfer field by field.
// Depends on ftpd_pkg only.

module ftpd_sample_checker import ftpd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic                cfg_pready,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output int                  mismatches,
  output int                  outstanding
);

  logic [GainW-1:0]  force_gain_q;
  logic [GainW-1:0]  torque_gain_q;
  int                byte_pos;
  logic [31:0]       word_acc;
  logic [31:0]       seq_held;
  logic [31:0]       last_seq;
  logic              status_bad;
  logic [AxisW-1:0]  axis_val [NumAxes];
  logic [CountW-1:0] drop_total;
  logic [CountW-1:0] bad_total;
  out_item_t         sample_queue [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // floor(counts * gain / 2^32), kept to the axis width
  function automatic logic [AxisW-1:0] scale_counts(logic [31:0] counts,
                                                    logic [GainW-1:0] gain);
    logic signed [73:0] prod;
    prod = $signed({{42{counts[31]}}, counts}) * $signed({34'd0, gain});
    prod = prod >>> 32;
    return prod[AxisW-1:0];
  endfunction

  function automatic logic [CountW-1:0] add_capped(logic [CountW-1:0] total,
                                                   logic [31:0] step);
    logic [CountW:0] sum;
    sum = {1'b0, total} + step;
    return (sum > {1'b0, CountMax}) ? CountMax : sum[CountW-1:0];
  endfunction

  function automatic void absorb_byte(in_item_t item);
    out_item_t   rec;
    logic [31:0] next_seq;
    int          axis;
    if (byte_pos < RecordBytes) begin
      word_acc = {word_acc[23:0], item.data_byte};
      if (byte_pos == SeqLast) begin
        seq_held = word_acc;
      end else if (byte_pos == StatusLast) begin
        status_bad = (word_acc != 0);
      end else if (byte_pos >= AxisFirst && byte_pos % 4 == 3) begin
        axis = (byte_pos - AxisFirst) / 4;
        axis_val[axis] = scale_counts(word_acc,
                                      (axis < ForceAxes) ? force_gain_q : torque_gain_q);
      end
      byte_pos++;
    end else begin
      byte_pos = Overlong;
    end
    if (!item.end_of_packet) return;

    rec = '0;
    if (byte_pos != RecordBytes || !item.source_ok) begin
      rec.outcome = OUTCOME_REJECT;
    end else if (status_bad) begin
      bad_total = add_capped(bad_total, 32'd1);
      rec.outcome = OUTCOME_BAD_STATUS;
      rec.sequence_number = seq_held;
    end else begin
      // zero as last sequence means nothing seen yet
      if (last_seq != 0) begin
        next_seq = last_seq + 32'd1;
        if (seq_held != next_seq)
          drop_total = add_capped(drop_total,
                                  (seq_held > next_seq) ? seq_held - next_seq : 32'd1);
      end
      last_seq = seq_held;
      rec.outcome         = OUTCOME_GOOD;
      rec.sequence_number = seq_held;
      rec.force_x         = axis_val[0];
      rec.force_y         = axis_val[1];
      rec.force_z         = axis_val[2];
      rec.torque_x        = axis_val[3];
      rec.torque_y        = axis_val[4];
      rec.torque_z        = axis_val[5];
    end
    rec.dropped_total    = drop_total;
    rec.bad_status_total = bad_total;
    byte_pos = 0;
    sample_queue.push_back(rec);
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      force_gain_q  = GainReset;
      torque_gain_q = GainReset;
      byte_pos      = 0;
      word_acc      = '0;
      seq_held      = '0;
      last_seq      = '0;
      status_bad    = 1'b0;
      drop_total    = '0;
      bad_total     = '0;
      for (int a = 0; a < NumAxes; a++) axis_val[a] = '0;
      sample_queue.delete();
      mismatches    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sample_queue.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no sample waiting: expected none, actual %h",
                   $time, out_data);
        end else begin
          want = sample_queue.pop_front();
          check_field("outcome", want.outcome, out_data.outcome);
          check_field("sequence_number", want.sequence_number, out_data.sequence_number);
          check_field("force_x", want.force_x, out_data.force_x);
          check_field("force_y", want.force_y, out_data.force_y);
          check_field("force_z", want.force_z, out_data.force_z);
          check_field("torque_x", want.torque_x, out_data.torque_x);
          check_field("torque_y", want.torque_y, out_data.torque_y);
          check_field("torque_z", want.torque_z, out_data.torque_z);
          check_field("dropped_total", want.dropped_total, out_data.dropped_total);
          check_field("bad_status_total", want.bad_status_total,
                      out_data.bad_status_total);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if ((cfg_paddr >> 3) == CfgAddrW'(REG_FORCE_GAIN))
          force_gain_q = cfg_pwdata[GainW-1:0];
        else if ((cfg_paddr >> 3) == CfgAddrW'(REG_TORQUE_GAIN))
          torque_gain_q = cfg_pwdata[GainW-1:0];
      end
      if (in_valid && !in_stall) absorb_byte(in_data);
    end
    outstanding = sample_queue.size();
  end

endmodule

// ----- dv/force_torque_packet_decoder_tb.sv -----
// Testbench top for force_torque_packet_decoder: clock, reset, datagram stimulus, gain
// writes and result-side stalls. Depends on ftpd_pkg and ftpd_sample_checker.

module force_torque_packet_decoder_tb;
  import ftpd_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int SettleCycles  = 16;
  localparam int SqueezeCycles = 400;
  localparam int TargetBytes   = 850;
  localparam int TargetRecords = 20;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;
  int                  mismatches;
  int                  outstanding;

  logic                brisk;
  logic                squeeze_req;
  logic [7:0]          frame [0:63];
  logic [31:0]         counts [NumAxes];
  int                  bytes_sent;
  int                  datagrams;

  always #5 clk = ~clk;

  force_torque_packet_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ftpd_sample_checker sample_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("force_torque_packet_decoder regression: fail");
    $finish;
  end

  initial begin : result_sink
    int hold;
    bit squeezed;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        hold = SqueezeCycles;
        squeezed = 1'b1;
      end else begin
        hold = brisk ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_byte(logic [7:0] b, logic eop, logic src);
    int       gap;
    in_item_t beat;
    gap = brisk ? 0 : $urandom_range(0, 7);
    beat.data_byte     = b;
    beat.end_of_packet = eop;
    beat.source_ok     = src;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // source_ok only matters on the closing byte; randomize it elsewhere
  task automatic send_span(int first, int last, bit close, logic src);
    for (int i = first; i <= last; i++)
      send_byte(frame[i], close && i == last,
                (close && i == last) ? src : 1'($urandom));
  endtask

  task automatic build_record(logic [31:0] seq, logic [31:0] status);
    logic [31:0] words [9];
    words[0] = seq;
    words[1] = $urandom;
    words[2] = status;
    for (int a = 0; a < NumAxes; a++) words[3 + a] = counts[a];
    for (int w = 0; w < 9; w++)
      for (int k = 0; k < 4; k++) frame[4 * w + k] = words[w][31 - 8 * k -: 8];
  endtask

  task automatic send_record(logic [31:0] seq, logic [31:0] status, logic src, int len);
    build_record(seq, status);
    for (int i = RecordBytes; i < len; i++) frame[i] = $urandom;
    send_span(0, len - 1, 1'b1, src);
    datagrams++;
  endtask

  // hold the sender until every result is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_gain(logic idx, logic [GainW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CfgAddrW'(idx) << 3;
    cfg_pwdata  <= {24'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic set_gains(logic [GainW-1:0] fg, logic [GainW-1:0] tg);
    drain();
    write_gain(REG_FORCE_GAIN, fg);
    write_gain(REG_TORQUE_GAIN, tg);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return GainReset;
      1:       return '0;
      2:       return {GainW{1'b1}};
      3:       return {8'($urandom), 32'($urandom)};
      default: return GainW'($urandom_range(1000, 10_000_000));
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] seq_prev;
    logic [31:0] seq;
    logic [31:0] status;
    int          kind;
    int          len;
    int          phase;
    int          phase_left;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    brisk       <= 1'b0;
    squeeze_req <= 1'b0;
    bytes_sent  = 0;
    datagrams   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    counts[0] = 32'h8000_0000;
    counts[1] = 32'h7FFF_FFFF;
    counts[2] = 32'hFFFF_FFFF;
    counts[3] = 32'h0000_0000;
    counts[4] = 32'h0000_0001;
    counts[5] = 32'h1234_5678;

    // one-byte datagram
    frame[0] = $urandom;
    send_span(0, 0, 1'b1, 1'b1);
    send_record(32'd5, 32'd0, 1'b1, RecordBytes);
    send_record(32'd6, 32'd0, 1'b0, RecordBytes);
    send_record(32'd7, 32'd1, 1'b1, RecordBytes);
    send_record(32'd10, 32'd0, 1'b1, RecordBytes);
    send_record(32'd3, 32'd0, 1'b1, RecordBytes);
    send_record(32'd3, 32'd0, 1'b1, RecordBytes);
    send_record(32'd0, 32'd0, 1'b1, RecordBytes);
    send_record(32'd100, 32'd0, 1'b1, RecordBytes);
    send_record(32'd101, 32'd0, 1'b1, RecordBytes + 4);
    send_record(32'd101, 32'h8000_0000, 1'b1, RecordBytes - 1);
    send_record(32'hFFFF_FFFF, 32'd0, 1'b1, RecordBytes);
    send_record(32'd0, 32'd0, 1'b1, RecordBytes);

    set_gains('0, {GainW{1'b1}});
    send_record(32'd1, 32'd0, 1'b1, RecordBytes);
    set_gains({GainW{1'b1}}, '0);
    send_record(32'd2, 32'd0, 1'b1, RecordBytes);

    // gain change after the first two force axes have landed
    for (int a = 0; a < NumAxes; a++) counts[a] = $urandom;
    build_record(32'd3, 32'd0);
    send_span(0, 19, 1'b0, 1'b0);
    set_gains(GainReset, {8'($urandom), 32'($urandom)});
    send_span(20, RecordBytes - 1, 1'b1, 1'b1);
    datagrams++;

    seq_prev   = 32'd3;
    bytes_sent = 0;
    datagrams  = 0;
    phase      = 0;
    phase_left = 0;
    while (bytes_sent < TargetBytes || datagrams < TargetRecords) begin
      if (phase_left == 0) begin
        set_gains(pick_gain(), pick_gain());
        phase++;
        phase_left = $urandom_range(8, 14);
        if (phase == 2) begin
          brisk       <= 1'b0;
          squeeze_req <= 1'b1;
        end else begin
          brisk <= ($urandom_range(0, 3) == 0);
        end
        @(posedge clk);
      end
      phase_left--;

      for (int a = 0; a < NumAxes; a++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: counts[a] = $urandom;
          5, 6:          counts[a] = 32'($urandom_range(0, 2000)) - 32'd1000;
          7:             counts[a] = 32'h8000_0000;
          8:             counts[a] = 32'h7FFF_FFFF;
          default:       counts[a] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        endcase
      end
      status = $urandom | (32'd1 << $urandom_range(0, 31));
      kind   = $urandom_range(0, 99);
      if (kind < 70) begin
        case ($urandom_range(0, 19))
          0:       seq = seq_prev + 32'($urandom_range(2, 50));
          1:       seq = $urandom;
          2:       seq = seq_prev;
          3:       seq = seq_prev - 32'($urandom_range(1, 5));
          4:       seq = 32'd0;
          default: seq = seq_prev + 32'd1;
        endcase
        send_record(seq, 32'd0, 1'b1, RecordBytes);
        seq_prev = seq;
      end else if (kind < 78) begin
        send_record(seq_prev + 32'd1, status, 1'b1, RecordBytes);
      end else if (kind < 84) begin
        send_record(seq_prev + 32'd1, $urandom_range(0, 1) ? 32'd0 : status, 1'b0,
                    RecordBytes);
      end else if (kind < 92) begin
        send_record(seq_prev + 32'd1, 32'd0, 1'($urandom), $urandom_range(1, RecordBytes - 1));
      end else if (kind < 96) begin
        send_record(seq_prev + 32'd1, 32'd0, 1'($urandom),
                    $urandom_range(RecordBytes + 1, RecordBytes + 9));
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) frame[i] = $urandom;
        send_span(0, len - 1, 1'b1, 1'($urandom));
        datagrams++;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("force_torque_packet_decoder regression: pass");
    end else begin
      $display("force_torque_packet_decoder regression: fail");
    end
    $finish;
  end

endmodule
